### rtl/core/scan_result_best_n_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan result table
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCAN_RESULT_BEST_N_TABLE_ASSERT_SVH
`define SCAN_RESULT_BEST_N_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define SBNT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbnt assertion failed");

`define SBNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbnt assertion failed");

`else

`define SBNT_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SBNT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/sbnt_pkg.sv
// ----------------------------------------------------------------------------
// sbnt_pkg
// Shared types and constants of the scan result table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbnt_pkg;

    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 64;
    localparam int SSID_WORDS     = 4;
    localparam int SSID_FIELD_W   = WORD_W * SSID_WORDS;
    localparam int MAX_SSID_BYTES = SSID_FIELD_W / BYTE_W;
    localparam int LEN_W          = 6;
    localparam int SIG_W          = 8;
    localparam int CHAN_W         = 8;
    localparam int AUTH_W         = 8;
    localparam int STATION_W      = 48;
    localparam int SLOT_W         = 3;

    localparam logic [AUTH_W-1:0] AUTH_SECURE_MASK = 8'd7;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_REPORT = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    typedef struct packed {
        logic [SIG_W-1:0]     signal;
        logic [CHAN_W-1:0]    channel;
        logic                 secured;
        logic [STATION_W-1:0] station;
    } entry_meta_t;

    typedef struct packed {
        logic clear;
        logic write;
        logic insert;
        logic shift;
    } cell_cmd_t;

    typedef struct packed {
        logic empty;
        logic match;
        logic weaker;
    } cell_flags_t;

endpackage

### rtl/core/sbnt_cell.sv
// ----------------------------------------------------------------------------
// sbnt_cell
// One table entry: holds an SSID and its metadata, compares it against the
// broadcast key, and takes its upper neighbor's contents on an insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbnt_cell
    import sbnt_pkg::*;
#(
    parameter int KEY_W = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  logic [KEY_W-1:0]  key_ssid,
    input  entry_meta_t       key_meta,
    input  logic [KEY_W-1:0]  prev_ssid,
    input  entry_meta_t       prev_meta,
    output logic [KEY_W-1:0]  ssid,
    output entry_meta_t       meta,
    output cell_flags_t       flags
);

    logic [KEY_W-1:0] ssid_reg;
    logic [KEY_W-1:0] ssid_next;
    entry_meta_t      meta_reg;
    entry_meta_t      meta_next;
    entry_meta_t      base_meta;

    always_comb
    begin
        ssid_next = ssid_reg;
        meta_next = meta_reg;
        base_meta = cmd.insert ? '0 : meta_reg;
        if (cmd.clear)
        begin
            ssid_next = '0;
            meta_next = '0;
        end
        else if (cmd.write)
        begin
            ssid_next         = key_ssid;
            meta_next         = base_meta;
            meta_next.station = key_meta.station;
            meta_next.secured = base_meta.secured | key_meta.secured;
            if (cmd.insert || (base_meta.signal == '0)
                || ($signed(key_meta.signal) > $signed(base_meta.signal)))
            begin
                meta_next.signal  = key_meta.signal;
                meta_next.channel = key_meta.channel;
            end
        end
        else if (cmd.shift)
        begin
            ssid_next = prev_ssid;
            meta_next = prev_meta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssid_reg <= '0;
            meta_reg <= '0;
        end
        else
        begin
            ssid_reg <= ssid_next;
            meta_reg <= meta_next;
        end
    end

    assign ssid         = ssid_reg;
    assign meta         = meta_reg;
    assign flags.empty  = (ssid_reg[BYTE_W-1:0] == '0);
    assign flags.match  = (ssid_reg == key_ssid);
    assign flags.weaker = ($signed(key_meta.signal) > $signed(meta_reg.signal));

endmodule

### rtl/core/sbnt_ctrl.sv
// ----------------------------------------------------------------------------
// sbnt_ctrl
// Sequencer of the scan result table: normalizes the SSID, collects the cell
// flags, picks the target slot, drives the cell commands and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scan_result_best_n_table_assert.svh"

module sbnt_ctrl
    import sbnt_pkg::*;
#(
    parameter int ENTRIES    = 8,
    parameter int SSID_BYTES = 32,
    parameter int KEY_W      = SSID_BYTES * 8,
    parameter int IDX_W      = $clog2(ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [WORD_W-1:0]     ssid_word0,
    input  logic [WORD_W-1:0]     ssid_word1,
    input  logic [WORD_W-1:0]     ssid_word2,
    input  logic [WORD_W-1:0]     ssid_word3,
    input  logic [LEN_W-1:0]      ssid_length,
    input  logic signed [SIG_W-1:0] signal_dbm,
    input  logic [CHAN_W-1:0]     radio_channel,
    input  logic [AUTH_W-1:0]     auth_bits,
    input  logic [STATION_W-1:0]  station_id,
    input  logic [SLOT_W-1:0]     read_slot,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  accepted,
    output logic [SLOT_W-1:0]     slot_used,
    output logic                  entry_valid,
    output logic [WORD_W-1:0]     out_ssid_word0,
    output logic [WORD_W-1:0]     out_ssid_word1,
    output logic [WORD_W-1:0]     out_ssid_word2,
    output logic [WORD_W-1:0]     out_ssid_word3,
    output logic [CHAN_W-1:0]     out_channel,
    output logic signed [SIG_W-1:0] out_signal,
    output logic                  out_secured,
    output logic [STATION_W-1:0]  out_station_id,
    input  logic [KEY_W-1:0]      cell_ssid [ENTRIES],
    input  entry_meta_t           cell_meta [ENTRIES],
    input  cell_flags_t           cell_flags [ENTRIES],
    output cell_cmd_t             cmd [ENTRIES],
    output logic [KEY_W-1:0]      key_ssid,
    output entry_meta_t           key_meta
);

    localparam logic [LEN_W-1:0] SSID_LEN_MAX = LEN_W'(SSID_BYTES);
    localparam logic [MAX_SSID_BYTES-1:0] ONE_B = {{(MAX_SSID_BYTES-1){1'b0}}, 1'b1};
    localparam logic [MAX_SSID_BYTES:0] ONE_L = {{MAX_SSID_BYTES{1'b0}}, 1'b1};
    localparam logic [ENTRIES-1:0] ONE_E = {{(ENTRIES-1){1'b0}}, 1'b1};

    state_t                    state_reg;
    state_t                    state_next;
    op_t                       op_reg;
    logic [KEY_W-1:0]          key_ssid_reg;
    entry_meta_t               key_meta_reg;
    logic [SLOT_W-1:0]         rd_slot_reg;
    logic [ENTRIES-1:0]        hit_reg;
    logic [ENTRIES-1:0]        weak_reg;

    logic [SSID_FIELD_W-1:0]   raw_ssid;
    logic [SSID_FIELD_W-1:0]   norm_ssid;
    logic [MAX_SSID_BYTES-1:0] zero_byte;
    logic [MAX_SSID_BYTES-1:0] first_zero;
    logic [MAX_SSID_BYTES-1:0] below_zero;
    logic [MAX_SSID_BYTES-1:0] keep;
    logic [MAX_SSID_BYTES:0]   len_mask;
    logic [LEN_W-1:0]          len_clip;

    logic                      in_take;
    logic                      commit;
    logic                      have_hit;
    logic                      have_weak;
    logic                      insert_mode;
    logic                      report_ok;
    logic [ENTRIES-1:0]        sel;
    logic [ENTRIES-1:0]        above;
    logic [ENTRIES-1:0]        write_vec;
    logic [ENTRIES-1:0]        shift_vec;
    logic [IDX_W-1:0]          sel_idx;
    logic [IDX_W+SLOT_W-1:0]   sel_wide;
    logic [IDX_W+SLOT_W-1:0]   rd_wide;
    logic [IDX_W-1:0]          rd_idx;
    logic                      rd_ok;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      accepted_reg;
    logic                      accepted_next;
    logic [SLOT_W-1:0]         slot_used_reg;
    logic [SLOT_W-1:0]         slot_used_next;
    logic                      entry_valid_reg;
    logic                      entry_valid_next;
    logic [SSID_FIELD_W-1:0]   out_ssid_reg;
    logic [SSID_FIELD_W-1:0]   out_ssid_next;
    entry_meta_t               out_meta_reg;
    entry_meta_t               out_meta_next;

    assign raw_ssid = {ssid_word3, ssid_word2, ssid_word1, ssid_word0};

    always_comb
    begin
        for (int i = 0; i < MAX_SSID_BYTES; i++)
        begin
            zero_byte[i] = (raw_ssid[i*BYTE_W +: BYTE_W] == '0);
        end
        first_zero = zero_byte & (~zero_byte + ONE_B);
        below_zero = first_zero - ONE_B;
        len_clip   = (ssid_length > SSID_LEN_MAX) ? SSID_LEN_MAX : ssid_length;
        len_mask   = (ONE_L << len_clip) - ONE_L;
        keep       = below_zero & len_mask[MAX_SSID_BYTES-1:0];
        for (int i = 0; i < MAX_SSID_BYTES; i++)
        begin
            norm_ssid[i*BYTE_W +: BYTE_W] = keep[i] ? raw_ssid[i*BYTE_W +: BYTE_W] : '0;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign commit   = (state_reg == ST_APPLY) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg               <= op_t'(op);
            key_ssid_reg         <= norm_ssid[KEY_W-1:0];
            key_meta_reg.signal  <= signal_dbm;
            key_meta_reg.channel <= radio_channel;
            key_meta_reg.secured <= |(auth_bits & AUTH_SECURE_MASK);
            key_meta_reg.station <= station_id;
            rd_slot_reg          <= read_slot;
        end
        if (state_reg == ST_EVAL)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                hit_reg[i]  <= cell_flags[i].empty || cell_flags[i].match;
                weak_reg[i] <= cell_flags[i].weaker;
            end
        end
        if (commit)
        begin
            accepted_reg    <= accepted_next;
            slot_used_reg   <= slot_used_next;
            entry_valid_reg <= entry_valid_next;
            out_ssid_reg    <= out_ssid_next;
            out_meta_reg    <= out_meta_next;
        end
    end

    assign key_ssid = key_ssid_reg;
    assign key_meta = key_meta_reg;

    always_comb
    begin
        have_hit    = |hit_reg;
        have_weak   = |weak_reg;
        insert_mode = !have_hit && have_weak;
        sel         = have_hit ? (hit_reg & (~hit_reg + ONE_E))
                               : (weak_reg & (~weak_reg + ONE_E));
        above       = ~(sel | (sel - ONE_E));
        report_ok   = (op_reg == OP_REPORT) && (key_ssid_reg[BYTE_W-1:0] != '0)
                      && (have_hit || have_weak);
        sel_idx     = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel[i])
            begin
                sel_idx = sel_idx | IDX_W'(i);
            end
            write_vec[i]     = commit && report_ok && sel[i];
            shift_vec[i]     = commit && report_ok && insert_mode && above[i];
            cmd[i].clear     = commit && (op_reg == OP_CLEAR);
            cmd[i].write     = write_vec[i];
            cmd[i].insert    = insert_mode;
            cmd[i].shift     = shift_vec[i];
        end
        sel_wide = (IDX_W+SLOT_W)'(sel_idx);
        rd_wide  = (IDX_W+SLOT_W)'(rd_slot_reg);
        rd_idx   = rd_wide[IDX_W-1:0];
        rd_ok    = ({29'd0, rd_slot_reg} < 32'(ENTRIES));
    end

    always_comb
    begin
        accepted_next    = 1'b0;
        slot_used_next   = '0;
        entry_valid_next = 1'b0;
        out_ssid_next    = '0;
        out_meta_next    = '0;
        case (op_reg)
            OP_CLEAR:
            begin
                accepted_next = 1'b1;
            end
            OP_REPORT:
            begin
                if (report_ok)
                begin
                    accepted_next  = 1'b1;
                    slot_used_next = sel_wide[SLOT_W-1:0];
                end
            end
            OP_READ:
            begin
                if (rd_ok)
                begin
                    accepted_next    = 1'b1;
                    slot_used_next   = rd_slot_reg;
                    entry_valid_next = (cell_ssid[rd_idx][BYTE_W-1:0] != '0);
                    out_ssid_next    = SSID_FIELD_W'(cell_ssid[rd_idx]);
                    out_meta_next    = cell_meta[rd_idx];
                end
            end
            default:
            begin
                accepted_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = accepted_reg;
    assign slot_used      = slot_used_reg;
    assign entry_valid    = entry_valid_reg;
    assign out_ssid_word0 = out_ssid_reg[0*WORD_W +: WORD_W];
    assign out_ssid_word1 = out_ssid_reg[1*WORD_W +: WORD_W];
    assign out_ssid_word2 = out_ssid_reg[2*WORD_W +: WORD_W];
    assign out_ssid_word3 = out_ssid_reg[3*WORD_W +: WORD_W];
    assign out_channel    = out_meta_reg.channel;
    assign out_signal     = $signed(out_meta_reg.signal);
    assign out_secured    = out_meta_reg.secured;
    assign out_station_id = out_meta_reg.station;

    `SBNT_ASSERT_NEXT(a_accept_to_eval, clk, rst_n, in_take, state_reg == ST_EVAL)
    `SBNT_ASSERT_IMPL(a_single_write, clk, rst_n, 1'b1, $onehot0(write_vec))
    `SBNT_ASSERT_IMPL(a_shift_needs_insert, clk, rst_n, |shift_vec, insert_mode && |write_vec)
    `SBNT_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, commit, out_valid_reg)

endmodule

### rtl/core/scan_result_best_n_table.sv
// ----------------------------------------------------------------------------
// scan_result_best_n_table: table of the strongest scanned networks
// Flow: the key is registered on acceptance, the cell flags in the compare
// step, and the result in the commit (shift/write) step. No new transaction
// is taken until the last commits; a stalled result holds the commit step.
// Reset: rst_n asynchronously empties the table and idles the control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_result_best_n_table
    import sbnt_pkg::*;
#(
    parameter int ENTRIES    = 8,
    parameter int SSID_BYTES = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              op,
    input  logic [WORD_W-1:0]       ssid_word0,
    input  logic [WORD_W-1:0]       ssid_word1,
    input  logic [WORD_W-1:0]       ssid_word2,
    input  logic [WORD_W-1:0]       ssid_word3,
    input  logic [LEN_W-1:0]        ssid_length,
    input  logic signed [SIG_W-1:0] signal_dbm,
    input  logic [CHAN_W-1:0]       radio_channel,
    input  logic [AUTH_W-1:0]       auth_bits,
    input  logic [STATION_W-1:0]    station_id,
    input  logic [SLOT_W-1:0]       read_slot,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    accepted,
    output logic [SLOT_W-1:0]       slot_used,
    output logic                    entry_valid,
    output logic [WORD_W-1:0]       out_ssid_word0,
    output logic [WORD_W-1:0]       out_ssid_word1,
    output logic [WORD_W-1:0]       out_ssid_word2,
    output logic [WORD_W-1:0]       out_ssid_word3,
    output logic [CHAN_W-1:0]       out_channel,
    output logic signed [SIG_W-1:0] out_signal,
    output logic                    out_secured,
    output logic [STATION_W-1:0]    out_station_id
);

    localparam int KEY_W = SSID_BYTES * BYTE_W;
    localparam int IDX_W = $clog2(ENTRIES);

    logic [KEY_W-1:0] cell_ssid [ENTRIES];
    entry_meta_t      cell_meta [ENTRIES];
    cell_flags_t      cell_flags [ENTRIES];
    cell_cmd_t        cmd [ENTRIES];
    logic [KEY_W-1:0] key_ssid;
    entry_meta_t      key_meta;

    sbnt_ctrl #(
        .ENTRIES    (ENTRIES),
        .SSID_BYTES (SSID_BYTES),
        .KEY_W      (KEY_W),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .ssid_word0     (ssid_word0),
        .ssid_word1     (ssid_word1),
        .ssid_word2     (ssid_word2),
        .ssid_word3     (ssid_word3),
        .ssid_length    (ssid_length),
        .signal_dbm     (signal_dbm),
        .radio_channel  (radio_channel),
        .auth_bits      (auth_bits),
        .station_id     (station_id),
        .read_slot      (read_slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .slot_used      (slot_used),
        .entry_valid    (entry_valid),
        .out_ssid_word0 (out_ssid_word0),
        .out_ssid_word1 (out_ssid_word1),
        .out_ssid_word2 (out_ssid_word2),
        .out_ssid_word3 (out_ssid_word3),
        .out_channel    (out_channel),
        .out_signal     (out_signal),
        .out_secured    (out_secured),
        .out_station_id (out_station_id),
        .cell_ssid      (cell_ssid),
        .cell_meta      (cell_meta),
        .cell_flags     (cell_flags),
        .cmd            (cmd),
        .key_ssid       (key_ssid),
        .key_meta       (key_meta)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KEY_W-1:0] prev_ssid;
        entry_meta_t      prev_meta;

        if (i == 0)
        begin : g_head
            assign prev_ssid = '0;
            assign prev_meta = '0;
        end
        else
        begin : g_link
            assign prev_ssid = cell_ssid[i-1];
            assign prev_meta = cell_meta[i-1];
        end

        sbnt_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd[i]),
            .key_ssid  (key_ssid),
            .key_meta  (key_meta),
            .prev_ssid (prev_ssid),
            .prev_meta (prev_meta),
            .ssid      (cell_ssid[i]),
            .meta      (cell_meta[i]),
            .flags     (cell_flags[i])
        );
    end

endmodule
